FILE: src/prq_pkg.sv
package prq_pkg;

  localparam int unsigned QueueDepthDefault = 64;

  localparam int unsigned IdW    = 16;
  localparam int unsigned PrioW  = 7;
  localparam int unsigned ThrW   = 15;
  localparam int unsigned SeedW  = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 32;

  localparam logic [SeedW-1:0] LcgMul = 32'd1103515245;
  localparam logic [SeedW-1:0] LcgInc = 32'd12345;

  localparam logic [PrioW-1:0] IdlePrioRst = 7'd0;
  localparam logic [PrioW-1:0] RtPrioRst   = 7'd100;
  localparam logic [ThrW-1:0]  SkipThrRst  = 15'h1a00;
  localparam logic [SeedW-1:0] SeedRst     = 32'd1;

  typedef enum logic [1:0] {
    REQ_ENQ    = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_RESCHED = 2'd2,
    REQ_NONE   = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CFG_IDLE_PRIO = 2'd0,
    CFG_RT_PRIO   = 2'd1,
    CFG_SKIP_THR  = 2'd2,
    CFG_SEED      = 2'd3
  } cfg_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_SCAN,    // find insert position
    S_INS_SHIFT,   // move tail up one slot
    S_REM_SCAN,    // search id
    S_SEL_LD0,     // fetch head entry
    S_SEL_LD1,     // latch head, fetch its successor
    S_SEL_WALK,    // evaluate current entry
    S_SEL_MUL,     // multiply step of generator
    S_SEL_ADD,     // add step of generator and compare
    S_SEL_GROUP,   // skip priority group
    S_UNL_SHIFT,   // move tail down one slot
    S_DONE
  } state_e;

endpackage

FILE: src/priority_run_queue_with_random_skip.sv
// Priority run queue: entries (thread id, priority) kept sorted by falling
// priority, FIFO within a priority, in one RAM holding id and priority side
// by side. A request is taken when start_i is high and busy_o low; the block
// stays busy until done_o strobes for one cycle with status_o, picked_id_o
// and picked_priority_o. The receiver cannot stall, so the result must be
// captured in that cycle. An enqueue scans for its position and shifts the
// tail up (straight to done when full); a remove scans for the id and shifts
// the tail down. A reschedule loads the head, visits entries, takes a
// generator draw (multiply, then add) per skip decision, steps over each
// skipped group, unlinks the picked entry, then signals done; a requeue
// first adds the enqueue scan and shift plus a fetch of the head. busy_o
// falls after the done cycle, and the next request can then be taken.
module priority_run_queue_with_random_skip #(
  parameter int unsigned QueueDepth = prq_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic [1:0]                  req_type_i,
  input  logic [prq_pkg::IdW-1:0]     thread_id_i,
  input  logic [prq_pkg::PrioW-1:0]   priority_req_i,
  input  logic                        requeue_old_i,
  input  logic                        cpu_disabled_i,
  input  logic                        cfg_we_i,
  input  logic [prq_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [prq_pkg::CfgDatW-1:0] cfg_data_i,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [prq_pkg::IdW-1:0]     picked_id_o,
  output logic [prq_pkg::PrioW-1:0]   picked_priority_o
);

  localparam int unsigned AW   = $clog2(QueueDepth);
  localparam int unsigned LW   = $clog2(QueueDepth + 1);
  localparam int unsigned EW   = prq_pkg::IdW + prq_pkg::PrioW;
  localparam logic [LW-1:0] DepthL = LW'(QueueDepth);

  // configuration
  logic [prq_pkg::PrioW-1:0] idle_prio_q, rt_prio_q;
  logic [prq_pkg::ThrW-1:0]  skip_thr_q;
  logic [prq_pkg::SeedW-1:0] seed_q, lcg_q, lcg_d, prod_q, prod_d;

  prq_pkg::state_e state_q, state_d;
  logic [LW-1:0] len_q, len_d;
  logic [LW-1:0] pos_q, pos_d;     // walk / shift index
  logic [LW-1:0] slot_q, slot_d;   // insert position
  logic [LW-1:0] nxt;
  logic [prq_pkg::IdW-1:0]   id_q, id_d;
  logic [prq_pkg::PrioW-1:0] prio_q, prio_d;
  logic                      resched_q, resched_d, dis_q, dis_d;
  logic [prq_pkg::IdW-1:0]   cur_id_q, cur_id_d;     // entry pos_q
  logic [prq_pkg::PrioW-1:0] cur_prio_q, cur_prio_d;
  logic [prq_pkg::PrioW-1:0] grp_q, grp_d;           // group being skipped
  logic [prq_pkg::IdW-1:0]   pick_id_q, pick_id_d;
  logic [prq_pkg::PrioW-1:0] pick_prio_q, pick_prio_d;
  logic [1:0]                status_q, status_d;
  logic [prq_pkg::ThrW-1:0]  draw;

  // RAM
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [LW-1:0] rd_idx;
  logic [prq_pkg::IdW-1:0]   r_id;
  logic [prq_pkg::PrioW-1:0] r_prio;

  assign r_id   = rdata[EW-1:prq_pkg::PrioW];
  assign r_prio = rdata[prq_pkg::PrioW-1:0];
  assign raddr  = rd_idx[AW-1:0];
  assign nxt    = pos_q + LW'(1);

  prq_ram #(.Width(EW), .Depth(QueueDepth)) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy_o            = (state_q != prq_pkg::S_IDLE);
  assign done_o            = (state_q == prq_pkg::S_DONE);
  assign status_o          = status_q;
  assign picked_id_o       = pick_id_q;
  assign picked_priority_o = pick_prio_q;

  // sequencer; by default the RAM reads the entry after pos_q
  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    pos_d       = pos_q;
    slot_d      = slot_q;
    id_d        = id_q;
    prio_d      = prio_q;
    resched_d   = resched_q;
    dis_d       = dis_q;
    cur_id_d    = cur_id_q;
    cur_prio_d  = cur_prio_q;
    grp_d       = grp_q;
    lcg_d       = lcg_q;
    prod_d      = prod_q;
    pick_id_d   = pick_id_q;
    pick_prio_d = pick_prio_q;
    status_d    = status_q;
    draw        = '0;
    rd_idx      = nxt;
    we          = 1'b0;
    waddr       = pos_q[AW-1:0];
    wdata       = {id_q, prio_q};
    case (state_q)
      prq_pkg::S_IDLE: begin
        rd_idx = '0;
        if (start_i) begin
          id_d        = thread_id_i;
          prio_d      = priority_req_i;
          dis_d       = cpu_disabled_i;
          resched_d   = (req_type_i == prq_pkg::REQ_RESCHED);
          pos_d       = '0;
          status_d    = prq_pkg::ST_OK;
          pick_id_d   = '0;
          pick_prio_d = '0;
          case (req_type_i)
            prq_pkg::REQ_ENQ: begin
              if (len_q == DepthL) begin
                status_d = prq_pkg::ST_FULL;
                state_d  = prq_pkg::S_DONE;
              end else begin
                state_d = prq_pkg::S_INS_SCAN;
              end
            end
            prq_pkg::REQ_REMOVE: state_d = prq_pkg::S_REM_SCAN;
            prq_pkg::REQ_RESCHED: begin
              if (requeue_old_i && len_q == DepthL) begin
                status_d = prq_pkg::ST_FULL;
                state_d  = prq_pkg::S_DONE;
              end else if (requeue_old_i) begin
                state_d = prq_pkg::S_INS_SCAN;
              end else if (len_q == '0) begin
                status_d = prq_pkg::ST_EMPTY;
                state_d  = prq_pkg::S_DONE;
              end else begin
                state_d = prq_pkg::S_SEL_LD1;
              end
            end
            default: state_d = prq_pkg::S_DONE;
          endcase
        end
      end
      // rdata is entry pos_q; stop at the first lower priority
      prq_pkg::S_INS_SCAN: begin
        if (pos_q < len_q && r_prio >= prio_q) begin
          pos_d = nxt;
        end else begin
          slot_d  = pos_q;
          pos_d   = len_q;
          rd_idx  = len_q - LW'(1);
          state_d = prq_pkg::S_INS_SHIFT;
        end
      end
      // rdata is entry pos_q-1; copy up until the slot is reached
      prq_pkg::S_INS_SHIFT: begin
        we = 1'b1;
        if (pos_q > slot_q) begin
          wdata  = rdata;
          rd_idx = pos_q - LW'(2);
          pos_d  = pos_q - LW'(1);
        end else begin
          len_d   = len_q + LW'(1);
          state_d = resched_q ? prq_pkg::S_SEL_LD0 : prq_pkg::S_DONE;
        end
      end
      // rdata is entry pos_q
      prq_pkg::S_REM_SCAN: begin
        if (pos_q >= len_q) begin
          status_d = prq_pkg::ST_NOTFOUND;
          state_d  = prq_pkg::S_DONE;
        end else if (r_id == id_q) begin
          state_d = prq_pkg::S_UNL_SHIFT;
        end else begin
          pos_d = nxt;
        end
      end
      prq_pkg::S_SEL_LD0: begin
        rd_idx  = '0;
        state_d = prq_pkg::S_SEL_LD1;
      end
      prq_pkg::S_SEL_LD1: begin
        cur_id_d   = r_id;
        cur_prio_d = r_prio;
        pos_d      = '0;
        rd_idx     = LW'(1);
        state_d    = prq_pkg::S_SEL_WALK;
      end
      // cur is entry pos_q, rdata its successor
      prq_pkg::S_SEL_WALK: begin
        if (cur_prio_q <= idle_prio_q) begin
          pick_id_d   = cur_id_q;
          pick_prio_d = cur_prio_q;
          state_d     = prq_pkg::S_UNL_SHIFT;
        end else if (dis_q) begin
          if (nxt < len_q) begin
            cur_id_d   = r_id;
            cur_prio_d = r_prio;
            pos_d      = nxt;
            rd_idx     = pos_q + LW'(2);
          end else begin
            status_d = prq_pkg::ST_EMPTY;
            state_d  = prq_pkg::S_DONE;
          end
        end else if (cur_prio_q >= rt_prio_q || nxt >= len_q || r_prio == idle_prio_q) begin
          pick_id_d   = cur_id_q;
          pick_prio_d = cur_prio_q;
          state_d     = prq_pkg::S_UNL_SHIFT;
        end else begin
          state_d = prq_pkg::S_SEL_MUL;
        end
      end
      prq_pkg::S_SEL_MUL: begin
        prod_d  = ((lcg_q == '0) ? seed_q : lcg_q) * prq_pkg::LcgMul;
        state_d = prq_pkg::S_SEL_ADD;
      end
      prq_pkg::S_SEL_ADD: begin
        lcg_d = prod_q + prq_pkg::LcgInc;
        draw  = lcg_d[30:16];
        if (draw > skip_thr_q) begin
          pick_id_d   = cur_id_q;
          pick_prio_d = cur_prio_q;
          state_d     = prq_pkg::S_UNL_SHIFT;
        end else begin
          grp_d   = cur_prio_q;
          state_d = prq_pkg::S_SEL_GROUP;
        end
      end
      // advance to the first entry of the next lower priority, or the last
      prq_pkg::S_SEL_GROUP: begin
        if (nxt < len_q && cur_prio_q == grp_q) begin
          cur_id_d   = r_id;
          cur_prio_d = r_prio;
          pos_d      = nxt;
          rd_idx     = pos_q + LW'(2);
        end else begin
          state_d = prq_pkg::S_SEL_WALK;
        end
      end
      // rdata is entry pos_q+1; copy down to close the gap
      prq_pkg::S_UNL_SHIFT: begin
        if (nxt < len_q) begin
          we     = 1'b1;
          wdata  = rdata;
          rd_idx = pos_q + LW'(2);
          pos_d  = nxt;
        end else begin
          len_d   = len_q - LW'(1);
          state_d = prq_pkg::S_DONE;
        end
      end
      prq_pkg::S_DONE: state_d = prq_pkg::S_IDLE;
      default: state_d = prq_pkg::S_IDLE;
    endcase
  end

  // state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= prq_pkg::S_IDLE;
      len_q       <= '0;
      pos_q       <= '0;
      slot_q      <= '0;
      id_q        <= '0;
      prio_q      <= '0;
      resched_q   <= 1'b0;
      dis_q       <= 1'b0;
      cur_id_q    <= '0;
      cur_prio_q  <= '0;
      grp_q       <= '0;
      prod_q      <= '0;
      pick_id_q   <= '0;
      pick_prio_q <= '0;
      status_q    <= prq_pkg::ST_OK;
      idle_prio_q <= prq_pkg::IdlePrioRst;
      rt_prio_q   <= prq_pkg::RtPrioRst;
      skip_thr_q  <= prq_pkg::SkipThrRst;
      seed_q      <= prq_pkg::SeedRst;
      lcg_q       <= prq_pkg::SeedRst;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      pos_q       <= pos_d;
      slot_q      <= slot_d;
      id_q        <= id_d;
      prio_q      <= prio_d;
      resched_q   <= resched_d;
      dis_q       <= dis_d;
      cur_id_q    <= cur_id_d;
      cur_prio_q  <= cur_prio_d;
      grp_q       <= grp_d;
      prod_q      <= prod_d;
      pick_id_q   <= pick_id_d;
      pick_prio_q <= pick_prio_d;
      status_q    <= status_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          prq_pkg::CFG_IDLE_PRIO: idle_prio_q <= cfg_data_i[prq_pkg::PrioW-1:0];
          prq_pkg::CFG_RT_PRIO:   rt_prio_q   <= cfg_data_i[prq_pkg::PrioW-1:0];
          prq_pkg::CFG_SKIP_THR:  skip_thr_q  <= cfg_data_i[prq_pkg::ThrW-1:0];
          prq_pkg::CFG_SEED:      seed_q      <= cfg_data_i;
          default: ;
        endcase
      end
      // a seed write also restarts the generator
      if (cfg_we_i && cfg_idx_i == prq_pkg::CFG_SEED) begin
        lcg_q <= cfg_data_i;
      end else begin
        lcg_q <= lcg_d;
      end
    end
  end

`ifndef SYNTHESIS
  a_done_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> busy_o);
  a_done_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |=> !done_o);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o);
  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni) len_q <= DepthL);
  a_fail_no_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != prq_pkg::ST_OK) |-> (picked_id_o == '0));
`endif

endmodule

FILE: src/prq_ram.sv
module prq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

FILE: tb/sv/prq_checker.sv
// Watches request and result transactions, models the run queue and compares.
module prq_checker #(
  parameter int unsigned Depth = prq_pkg::QueueDepthDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic                        busy_i,
  input  logic [1:0]                  req_type_i,
  input  logic [prq_pkg::IdW-1:0]     thread_id_i,
  input  logic [prq_pkg::PrioW-1:0]   priority_req_i,
  input  logic                        requeue_old_i,
  input  logic                        cpu_disabled_i,
  input  logic                        cfg_we_i,
  input  logic [prq_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [prq_pkg::CfgDatW-1:0] cfg_data_i,
  input  logic                        done_i,
  input  logic [1:0]                  status_i,
  input  logic [prq_pkg::IdW-1:0]     picked_id_i,
  input  logic [prq_pkg::PrioW-1:0]   picked_priority_i,
  output int                          fail_count_o,
  output int                          pending_o,
  output int                          picks_o
);

  localparam int unsigned IdW   = prq_pkg::IdW;
  localparam int unsigned PrioW = prq_pkg::PrioW;
  localparam int unsigned ThrW  = prq_pkg::ThrW;
  localparam int unsigned SeedW = prq_pkg::SeedW;

  typedef struct packed {
    prq_pkg::status_e status;
    logic [IdW-1:0]   id;
    logic [PrioW-1:0] prio;
  } outcome_t;

  // model state
  logic [IdW-1:0]   q_id [Depth];
  logic [PrioW-1:0] q_prio [Depth];
  int               q_len;
  logic [PrioW-1:0] idle_prio, rt_prio;
  logic [ThrW-1:0]  skip_thr;
  logic [SeedW-1:0] seed, lcg;
  outcome_t         expected_q [$];

  assign pending_o = expected_q.size();

  function automatic logic [ThrW-1:0] next_draw();
    if (lcg == '0) lcg = seed;
    lcg = lcg * prq_pkg::LcgMul + prq_pkg::LcgInc;
    return lcg[30:16];
  endfunction

  function automatic bit enqueue_entry(logic [IdW-1:0] id, logic [PrioW-1:0] p);
    int pos;
    pos = 0;
    if (q_len >= Depth) return 0;
    while (pos < q_len && q_prio[pos] >= p) pos++;
    for (int k = q_len; k > pos; k--) begin
      q_id[k] = q_id[k-1];
      q_prio[k] = q_prio[k-1];
    end
    q_id[pos] = id;
    q_prio[pos] = p;
    q_len++;
    return 1;
  endfunction

  function automatic void drop_entry(int pos);
    for (int k = pos; k + 1 < q_len; k++) begin
      q_id[k] = q_id[k+1];
      q_prio[k] = q_prio[k+1];
    end
    q_len--;
  endfunction

  function automatic int pick_index(bit disabled);
    int i;
    logic [PrioW-1:0] p;
    i = 0;
    if (disabled) begin
      while (i < q_len && q_prio[i] > idle_prio) i++;
      return i;
    end
    while (i < q_len && q_prio[i] > idle_prio) begin
      p = q_prio[i];
      if (p >= rt_prio) break;
      if (i + 1 >= q_len) break;
      if (q_prio[i+1] == idle_prio) break;
      if (next_draw() > skip_thr) break;
      while (i + 1 < q_len && q_prio[i] == p) i++;
    end
    return i;
  endfunction

  function automatic outcome_t schedule(prq_pkg::req_e req, logic [IdW-1:0] id,
                                        logic [PrioW-1:0] p, bit requeue, bit disabled);
    outcome_t r;
    int i;
    r = '{prq_pkg::ST_OK, '0, '0};
    case (req)
      prq_pkg::REQ_ENQ: begin
        if (!enqueue_entry(id, p)) r.status = prq_pkg::ST_FULL;
      end
      prq_pkg::REQ_REMOVE: begin
        i = 0;
        while (i < q_len && q_id[i] != id) i++;
        if (i < q_len) drop_entry(i);
        else r.status = prq_pkg::ST_NOTFOUND;
      end
      prq_pkg::REQ_RESCHED: begin
        if (requeue && !enqueue_entry(id, p)) r.status = prq_pkg::ST_FULL;
        else if (q_len == 0) r.status = prq_pkg::ST_EMPTY;
        else begin
          i = pick_index(disabled);
          if (i < q_len) begin
            r.id = q_id[i];
            r.prio = q_prio[i];
            drop_entry(i);
          end else begin
            r.status = prq_pkg::ST_EMPTY;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t exp_r;
    if (!rst_ni) begin
      q_len = 0;
      idle_prio = prq_pkg::IdlePrioRst;
      rt_prio = prq_pkg::RtPrioRst;
      skip_thr = prq_pkg::SkipThrRst;
      seed = prq_pkg::SeedRst;
      lcg = prq_pkg::SeedRst;
      expected_q.delete();
      fail_count_o = 0;
      picks_o = 0;
    end else begin
      // results first: a transaction finishing this edge predates any new start
      if (done_i) begin
        if (expected_q.size() == 0) begin
          $error("result with nothing expected: status=%0d", status_i);
          fail_count_o++;
        end else begin
          exp_r = expected_q.pop_front();
          if (status_i !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status_i);
            fail_count_o++;
          end
          if (picked_id_i !== exp_r.id) begin
            $error("picked_id: expected %0h, got %0h", exp_r.id, picked_id_i);
            fail_count_o++;
          end
          if (picked_priority_i !== exp_r.prio) begin
            $error("picked_priority: expected %0d, got %0d", exp_r.prio,
                   picked_priority_i);
            fail_count_o++;
          end
          if (exp_r.status == prq_pkg::ST_OK && exp_r.id != 0) picks_o++;
        end
      end
      if (cfg_we_i) begin
        case (prq_pkg::cfg_e'(cfg_idx_i))
          prq_pkg::CFG_IDLE_PRIO: idle_prio = cfg_data_i[PrioW-1:0];
          prq_pkg::CFG_RT_PRIO:   rt_prio = cfg_data_i[PrioW-1:0];
          prq_pkg::CFG_SKIP_THR:  skip_thr = cfg_data_i[ThrW-1:0];
          prq_pkg::CFG_SEED: begin
            seed = cfg_data_i;
            lcg = cfg_data_i;
          end
          default: ;
        endcase
      end
      if (start_i && !busy_i)
        expected_q.push_back(schedule(prq_pkg::req_e'(req_type_i), thread_id_i,
                                      priority_req_i, requeue_old_i, cpu_disabled_i));
    end
  end

endmodule

FILE: tb/sv/tb_priority_run_queue_with_random_skip.sv
// Stimulus and verdict for the priority run queue.
module tb_priority_run_queue_with_random_skip;

  localparam int Depth = prq_pkg::QueueDepthDefault;
  localparam int WatchdogLimit = 20000;
  localparam int RandomItems = 1600;
  localparam int unsigned IdW     = prq_pkg::IdW;
  localparam int unsigned PrioW   = prq_pkg::PrioW;
  localparam int unsigned CfgIdxW = prq_pkg::CfgIdxW;
  localparam int unsigned CfgDatW = prq_pkg::CfgDatW;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start_i = 1'b0;
  logic               busy_o;
  logic [1:0]         req_type_i = '0;
  logic [IdW-1:0]     thread_id_i = '0;
  logic [PrioW-1:0]   priority_req_i = '0;
  logic               requeue_old_i = 1'b0;
  logic               cpu_disabled_i = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDatW-1:0] cfg_data_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic [IdW-1:0]     picked_id_o;
  logic [PrioW-1:0]   picked_priority_o;
  int                 fail_count, pending, picks;
  int                 idle_cycles = 0;
  int                 sent = 0;
  int                 occupancy = 0;

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  priority_run_queue_with_random_skip #(.QueueDepth(Depth)) u_dut (.*);

  prq_checker #(.Depth(Depth)) u_checker (
    .clk_i, .rst_ni, .start_i, .busy_i(busy_o), .req_type_i, .thread_id_i,
    .priority_req_i, .requeue_old_i, .cpu_disabled_i, .cfg_we_i, .cfg_idx_i,
    .cfg_data_i, .done_i(done_o), .status_i(status_o), .picked_id_i(picked_id_o),
    .picked_priority_i(picked_priority_o), .fail_count_o(fail_count),
    .pending_o(pending), .picks_o(picks)
  );

  // watchdog on cycles without any accepted transaction or result
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || !rst_ni) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("watchdog expired with %0d results outstanding", pending);
      $display("** priority_run_queue_with_random_skip: FAILED **");
      $finish;
    end
  end

  // start stays high into a zero-gap follow-up; a gap drops it first
  task automatic issue(prq_pkg::req_e req, logic [IdW-1:0] id, logic [PrioW-1:0] p,
                       bit requeue, bit disabled, int gap);
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_type_i <= req;
    thread_id_i <= id;
    priority_req_i <= p;
    requeue_old_i <= requeue;
    cpu_disabled_i <= disabled;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
    sent++;
    // rough occupancy for steering the mix
    if (req == prq_pkg::REQ_ENQ && occupancy < Depth) occupancy++;
    else if (req == prq_pkg::REQ_REMOVE && occupancy > 0) occupancy--;
    else if (req == prq_pkg::REQ_RESCHED) begin
      if (requeue && occupancy < Depth) occupancy++;
      if (occupancy > 0) occupancy--;
    end
  endtask

  task automatic drain();
    start_i <= 1'b0;
    while (pending != 0 || busy_o) @(negedge clk_i);
    repeat (2 * Depth + 40) @(negedge clk_i);
  endtask

  task automatic write_reg(prq_pkg::cfg_e idx, logic [CfgDatW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [PrioW-1:0] rand_prio();
    case ($urandom_range(0, 5))
      0: return 7'd0;
      1: return 7'd127;
      2: return PrioW'($urandom_range(95, 105));
      default: return PrioW'($urandom_range(1, 12));
    endcase
  endfunction

  task automatic random_phase(int n, bit flush_midway);
    prq_pkg::req_e req;
    int gap;
    bit no_gaps;
    no_gaps = 0;
    for (int k = 0; k < n; k++) begin
      if (k % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
      gap = no_gaps ? 0 : $urandom_range(0, 17);
      if (flush_midway && k == n / 2) drain();
      // keep the queue mid-full most of the time, sometimes push to full
      case ($urandom_range(0, 9))
        0, 1, 2: req = (occupancy < 40 || $urandom_range(0, 3) == 0) ?
                       prq_pkg::REQ_ENQ : prq_pkg::REQ_RESCHED;
        3, 4, 5, 6: req = prq_pkg::REQ_RESCHED;
        7, 8: req = prq_pkg::REQ_REMOVE;
        default: req = ($urandom_range(0, 3) == 0) ? prq_pkg::REQ_NONE : prq_pkg::REQ_ENQ;
      endcase
      issue(req, ($urandom_range(0, 7) == 0) ? IdW'($urandom) : IdW'($urandom_range(0, 15)),
            rand_prio(), $urandom_range(0, 1), $urandom_range(0, 5) == 0, gap);
    end
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: empty, not found, ordering, rt and idle cases, skip paths
    issue(prq_pkg::REQ_RESCHED, 16'h0, 7'd0, 0, 0, 0);
    issue(prq_pkg::REQ_REMOVE, 16'hFFFF, 7'd0, 0, 0, 0);
    issue(prq_pkg::REQ_ENQ, 16'hFFFF, 7'd127, 0, 0, 0);
    issue(prq_pkg::REQ_ENQ, 16'h0001, 7'd5, 0, 0, 1);
    issue(prq_pkg::REQ_ENQ, 16'h0002, 7'd5, 0, 0, 0);
    issue(prq_pkg::REQ_ENQ, 16'h0003, 7'd0, 0, 0, 3);
    issue(prq_pkg::REQ_ENQ, 16'h0004, 7'd3, 0, 0, 0);
    issue(prq_pkg::REQ_ENQ, 16'h0001, 7'd9, 0, 0, 0);
    issue(prq_pkg::REQ_RESCHED, 16'h0000, 7'd0, 0, 1, 0);
    issue(prq_pkg::REQ_RESCHED, 16'h8000, 7'd100, 1, 0, 2);
    issue(prq_pkg::REQ_RESCHED, 16'h0000, 7'd0, 0, 0, 0);
    issue(prq_pkg::REQ_RESCHED, 16'h0000, 7'd0, 0, 0, 0);
    issue(prq_pkg::REQ_REMOVE, 16'h0001, 7'd0, 0, 0, 0);
    issue(prq_pkg::REQ_NONE, 16'h1234, 7'd44, 1, 1, 0);
    issue(prq_pkg::REQ_RESCHED, 16'h0000, 7'd0, 0, 1, 0);
    issue(prq_pkg::REQ_RESCHED, 16'h0000, 7'd0, 0, 1, 0);
    // fill to full, then overflow on enqueue and on requeue
    for (int k = 0; k < Depth; k++)
      issue(prq_pkg::REQ_ENQ, IdW'(k), PrioW'(k % 4 + 1), 0, 0, 0);
    issue(prq_pkg::REQ_ENQ, 16'h7777, 7'd1, 0, 0, 0);
    issue(prq_pkg::REQ_RESCHED, 16'h7777, 7'd1, 1, 0, 0);
    for (int k = 0; k < Depth + 1; k++) issue(prq_pkg::REQ_RESCHED, 16'h0, 7'd0, 0, 0, 0);
    occupancy = 0;
    drain();

    // random phases across register settings, extremes included
    write_reg(prq_pkg::CFG_IDLE_PRIO, 32'd0);
    write_reg(prq_pkg::CFG_RT_PRIO, 32'd100);
    write_reg(prq_pkg::CFG_SKIP_THR, 32'h7FFE);
    write_reg(prq_pkg::CFG_SEED, 32'hFFFF_FFFF);
    random_phase(RandomItems / 4, 1);
    drain();
    write_reg(prq_pkg::CFG_IDLE_PRIO, 32'd127);
    write_reg(prq_pkg::CFG_RT_PRIO, 32'd0);
    write_reg(prq_pkg::CFG_SKIP_THR, 32'd0);
    write_reg(prq_pkg::CFG_SEED, 32'd1);
    random_phase(RandomItems / 4, 0);
    drain();
    write_reg(prq_pkg::CFG_IDLE_PRIO, 32'd1);
    write_reg(prq_pkg::CFG_RT_PRIO, 32'd127);
    write_reg(prq_pkg::CFG_SKIP_THR, 32'h7FFF);
    write_reg(prq_pkg::CFG_SEED, $urandom | 32'd1);
    random_phase(RandomItems / 4, 0);
    drain();
    write_reg(prq_pkg::CFG_IDLE_PRIO, 32'd0);
    write_reg(prq_pkg::CFG_RT_PRIO, 32'd100);
    write_reg(prq_pkg::CFG_SKIP_THR, 32'h1a00);
    write_reg(prq_pkg::CFG_SEED, 32'hDEAD_BEEF);
    random_phase(RandomItems / 4, 0);
    drain();

    $display("ran %0d requests over four register settings, %0d threads picked",
             sent, picks);
    if (fail_count == 0) begin
      $display("** priority_run_queue_with_random_skip: PASSED **");
    end else begin
      $display("** priority_run_queue_with_random_skip: FAILED **");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/prq_pkg.sv
src/prq_ram.sv
src/priority_run_queue_with_random_skip.sv
tb/sv/prq_checker.sv
tb/sv/tb_priority_run_queue_with_random_skip.sv
